// ===== sv/reminder_alarm_table_assert.svh =====
// assertion macros for the reminder alarm table
`ifndef REMINDER_ALARM_TABLE_ASSERT_SVH
`define REMINDER_ALARM_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define RAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("reminder alarm table check failed");
`define RAT_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reminder alarm table reset check failed");
`else
`define RAT_ASSERT(lbl, clk, rst_n, prop)
`define RAT_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== sv/rat_pkg.sv =====
// shared types and constants of the reminder alarm table
`timescale 1ns / 1ps
`default_nettype none
package rat_pkg;
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_INVALID   = 3'd1;
  localparam logic [2:0] STAT_UNTRUSTED = 3'd2;
  localparam logic [2:0] STAT_NO_SPACE  = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  localparam logic [1:0] CFG_EPOCH = 2'd0;
  localparam logic [1:0] CFG_JUMP  = 2'd1;
  localparam logic [1:0] CFG_STALE = 2'd2;

  localparam logic [32:0] EPOCH_RST = 33'd1700000000;
  localparam logic [15:0] JUMP_RST  = 16'd60;
  localparam logic [31:0] STALE_RST = 32'(24 * 60 * 60);

  // remainder unit runs one quotient bit a cycle
  localparam logic [5:0] DIV_STEPS = 6'd33;

  typedef struct packed {
    logic [31:0] id;
    logic        kind;
    logic [33:0] fire;
    logic [31:0] period;
    logic [31:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== sv/reminder_alarm_table.sv =====
// reminder alarm table: slot memory, command sequencer and result registers
// add and cancel read memory once per active slot (a cancel stops at the matching slot);
// a tick makes an optional realign pass and a deliver pass and runs the remainder unit
// per periodic entry realigned or delivered; rejected commands never raise busy
// one command at a time: busy is high until out_valid; result lasts one cycle
// synchronous active-low reset clears slot valid bits and trust, sets next id and config defaults
`timescale 1ns / 1ps
`default_nettype none
`include "reminder_alarm_table_assert.svh"
module reminder_alarm_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [32:0] in_now_s,
  input  wire logic        in_mailbox_ready,
  input  wire logic        in_alarm_kind,
  input  wire logic [31:0] in_delay_s,
  input  wire logic [31:0] in_period_s,
  input  wire logic [31:0] in_task_id,
  input  wire logic [31:0] in_payload,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [31:0]      out_result_id,
  output logic             out_delivered,
  output logic [31:0]      out_delivered_payload,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [32:0] cfg_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;

  localparam logic [1:0] PH_REALIGN = 2'd0;
  localparam logic [1:0] PH_DELIVER = 2'd1;
  localparam logic [1:0] PH_IDSCAN  = 2'd2;
  localparam logic [1:0] PH_CANCEL  = 2'd3;

  localparam int SW = rat_pkg::SLOT_W;
  localparam int CW = rat_pkg::CNT_W;
  localparam int NS = rat_pkg::SLOTS;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [32:0]   epoch_r, epoch_nxt;
  logic [15:0]   jump_r, jump_nxt;
  logic [31:0]   stale_r, stale_nxt;
  logic [NS-1:0] active_r, active_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic          trusted_r, trusted_nxt;
  logic [32:0]   last_r, last_nxt;
  logic [32:0]   now_r, now_nxt;
  logic          ready_r, ready_nxt;
  logic          kind_r, kind_nxt;
  logic [33:0]   fire_r, fire_nxt;
  logic [31:0]   period_r, period_nxt;
  logic [31:0]   tid_r, tid_nxt;
  logic [31:0]   pay_r, pay_nxt;
  logic [SW-1:0] free_r, free_nxt;
  logic [NS:0]   used_r, used_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [31:0]   rid_r, rid_nxt;
  logic          dlv_r, dlv_nxt;
  logic [31:0]   dpay_r, dpay_nxt;

  logic              ram_we, ram_re;
  logic [SW-1:0]     ram_waddr, ram_raddr;
  rat_pkg::entry_t   ram_wdata, rd;
  logic [rat_pkg::ENTRY_W-1:0] ram_rdata;
  rat_pkg::div_req_t div_req;
  rat_pkg::div_rsp_t div_rsp;

  logic [SW-1:0] idx_s;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic [32:0]   jump_diff;
  logic          need_realign;
  logic          due;
  logic [32:0]   age;
  logic [31:0]   id_d;
  logic [31:0]   id_k;
  logic          chosen_found;
  logic [CW-1:0] chosen_k;
  logic [32:0]   chosen_sum;
  logic [31:0]   chosen_id;
  logic [33:0]   new_fire;

  rat_ram #(.WIDTH(rat_pkg::ENTRY_W), .DEPTH(NS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rat_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rd    = rat_pkg::entry_t'(ram_rdata);
  assign idx_s = idx_r[SW-1:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // first unused id offset after the scan
  always_comb begin
    chosen_found = 1'b0;
    chosen_k     = '0;
    for (int k = NS; k >= 0; k--) begin
      if (!used_r[k]) begin
        chosen_found = 1'b1;
        chosen_k     = CW'(k);
      end
    end
    chosen_sum = {1'b0, next_id_r} + 33'(chosen_k);
    if (chosen_sum[32]) begin
      chosen_sum = chosen_sum - 33'h0FFFFFFFF;
    end
    chosen_id = chosen_sum[31:0];
  end

  // time compares
  always_comb begin
    jump_diff    = (in_now_s > last_r) ? in_now_s - last_r : last_r - in_now_s;
    need_realign = !trusted_r || ((last_r != '0) && (jump_diff > {17'd0, jump_r}));
    due          = rd.fire <= {1'b0, now_r};
    age          = now_r - rd.fire[32:0];
    id_d         = rd.id - next_id_r;
    id_k         = (rd.id >= next_id_r) ? id_d : id_d - 32'd1;
    new_fire     = {1'b0, now_r} - {2'b00, div_rsp.rem} + {2'b00, rd.period};
  end

  // command sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    epoch_nxt   = epoch_r;
    jump_nxt    = jump_r;
    stale_nxt   = stale_r;
    active_nxt  = active_r;
    next_id_nxt = next_id_r;
    trusted_nxt = trusted_r;
    last_nxt    = last_r;
    now_nxt     = now_r;
    ready_nxt   = ready_r;
    kind_nxt    = kind_r;
    fire_nxt    = fire_r;
    period_nxt  = period_r;
    tid_nxt     = tid_r;
    pay_nxt     = pay_r;
    free_nxt    = free_r;
    used_nxt    = used_r;
    ov_nxt      = 1'b0;
    status_nxt  = status_r;
    rid_nxt     = rid_r;
    dlv_nxt     = dlv_r;
    dpay_nxt    = dpay_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_s;
    ram_wdata   = rd;
    ram_re      = 1'b0;
    ram_raddr   = idx_s;
    div_req     = '0;
    div_req.dividend = age;
    div_req.divisor  = rd.period;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        rat_pkg::CFG_EPOCH: epoch_nxt = cfg_data;
        rat_pkg::CFG_JUMP:  jump_nxt  = cfg_data[15:0];
        rat_pkg::CFG_STALE: stale_nxt = cfg_data[31:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          now_nxt    = in_now_s;
          ready_nxt  = in_mailbox_ready;
          kind_nxt   = in_alarm_kind;
          fire_nxt   = {1'b0, in_now_s} + {2'b00, in_delay_s};
          period_nxt = in_alarm_kind ? in_period_s : 32'd0;
          tid_nxt    = in_task_id;
          pay_nxt    = in_payload;
          free_nxt   = free_slot;
          used_nxt   = '0;
          idx_nxt    = '0;
          status_nxt = rat_pkg::STAT_OK;
          rid_nxt    = '0;
          dlv_nxt    = 1'b0;
          dpay_nxt   = '0;
          unique case (in_command)
            rat_pkg::CMD_TICK: begin
              if (in_now_s <= epoch_r) begin
                ov_nxt = 1'b1;
              end else begin
                trusted_nxt = 1'b1;
                phase_nxt   = need_realign ? PH_REALIGN : PH_DELIVER;
                state_nxt   = ST_RD;
              end
            end
            rat_pkg::CMD_ADD: begin
              if (in_delay_s == '0 || (in_alarm_kind && in_period_s == '0)) begin
                status_nxt = rat_pkg::STAT_INVALID;
                ov_nxt     = 1'b1;
              end else if (in_now_s <= epoch_r) begin
                status_nxt = rat_pkg::STAT_UNTRUSTED;
                ov_nxt     = 1'b1;
              end else if (!free_found) begin
                status_nxt = rat_pkg::STAT_NO_SPACE;
                ov_nxt     = 1'b1;
              end else begin
                phase_nxt = PH_IDSCAN;
                state_nxt = ST_RD;
              end
            end
            rat_pkg::CMD_CANCEL: begin
              if (in_task_id == '0) begin
                status_nxt = rat_pkg::STAT_INVALID;
                ov_nxt     = 1'b1;
              end else begin
                phase_nxt = PH_CANCEL;
                state_nxt = ST_RD;
              end
            end
            default: begin
              status_nxt = rat_pkg::STAT_INVALID;
              ov_nxt     = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        if (idx_r == CW'(NS)) begin
          // end of a pass over the table
          unique case (phase_r)
            PH_REALIGN: begin
              phase_nxt = PH_DELIVER;
              idx_nxt   = '0;
            end
            PH_DELIVER: begin
              last_nxt  = now_r;
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end
            PH_IDSCAN: begin
              if (chosen_found) begin
                ram_we            = 1'b1;
                ram_waddr         = free_r;
                ram_wdata.id      = chosen_id;
                ram_wdata.kind    = kind_r;
                ram_wdata.fire    = fire_r;
                ram_wdata.period  = period_r;
                ram_wdata.payload = pay_r;
                active_nxt[free_r] = 1'b1;
                next_id_nxt = (chosen_id == 32'hFFFFFFFF) ? 32'd1 : chosen_id + 32'd1;
                rid_nxt     = chosen_id;
              end else begin
                status_nxt = rat_pkg::STAT_NO_SPACE;
              end
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end
            PH_CANCEL: begin
              status_nxt = rat_pkg::STAT_NOT_FOUND;
              ov_nxt     = 1'b1;
              state_nxt  = ST_IDLE;
            end
            default: ;
          endcase
        end else if (active_r[idx_s]) begin
          ram_re    = 1'b1;
          state_nxt = ST_CHK;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      ST_CHK: begin
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_RD;
        unique case (phase_r)
          PH_REALIGN: begin
            if (due) begin
              if (!rd.kind) begin
                if (age >= {1'b0, stale_r}) begin
                  active_nxt[idx_s] = 1'b0;
                end
              end else if (rd.period != '0) begin
                div_req.start = 1'b1;
                idx_nxt       = idx_r;
                state_nxt     = ST_DIV;
              end
            end
          end
          PH_DELIVER: begin
            if (due) begin
              idx_nxt = idx_r;
              if (ready_r) begin
                dlv_nxt  = 1'b1;
                rid_nxt  = rd.id;
                dpay_nxt = rd.payload;
                if (!rd.kind) begin
                  active_nxt[idx_s] = 1'b0;
                end else if (rd.period != '0) begin
                  div_req.start = 1'b1;
                end
              end
              if (ready_r && rd.kind && rd.period != '0) begin
                state_nxt = ST_DIV;
              end else begin
                last_nxt  = now_r;
                ov_nxt    = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
          end
          PH_IDSCAN: begin
            if (id_k <= 32'(NS)) begin
              used_nxt[id_k[CW-1:0]] = 1'b1;
            end
          end
          PH_CANCEL: begin
            if (rd.id == tid_r) begin
              active_nxt[idx_s] = 1'b0;
              status_nxt = rat_pkg::STAT_OK;
              ov_nxt     = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
          default: ;
        endcase
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          ram_we         = 1'b1;
          ram_wdata.fire = new_fire;
          if (phase_r == PH_REALIGN) begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = ST_RD;
          end else begin
            last_nxt  = now_r;
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= PH_REALIGN;
      idx_r     <= '0;
      epoch_r   <= rat_pkg::EPOCH_RST;
      jump_r    <= rat_pkg::JUMP_RST;
      stale_r   <= rat_pkg::STALE_RST;
      active_r  <= '0;
      next_id_r <= 32'd1;
      trusted_r <= 1'b0;
      last_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      epoch_r   <= epoch_nxt;
      jump_r    <= jump_nxt;
      stale_r   <= stale_nxt;
      active_r  <= active_nxt;
      next_id_r <= next_id_nxt;
      trusted_r <= trusted_nxt;
      last_r    <= last_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // command operands and result word
  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    ready_r  <= ready_nxt;
    kind_r   <= kind_nxt;
    fire_r   <= fire_nxt;
    period_r <= period_nxt;
    tid_r    <= tid_nxt;
    pay_r    <= pay_nxt;
    free_r   <= free_nxt;
    used_r   <= used_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    dlv_r    <= dlv_nxt;
    dpay_r   <= dpay_nxt;
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = ov_r;
  assign out_status            = status_r;
  assign out_result_id         = rid_r;
  assign out_delivered         = dlv_r;
  assign out_delivered_payload = dpay_r;

  // checks
  `RAT_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> !busy && !out_valid)
  `RAT_ASSERT(a_chk_after_rd, clk, rst_n, (state_r == ST_CHK) |-> ($past(state_r) == ST_RD))
  `RAT_ASSERT(a_dlv_ok, clk, rst_n, (out_valid && out_delivered) |-> (out_status == rat_pkg::STAT_OK))
  `RAT_ASSERT(a_start_progress, clk, rst_n, (start && !busy) |=> (busy || out_valid))
endmodule
`default_nettype wire

// ===== sv/rat_ram.sv =====
// generic ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module rat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== sv/rat_mod.sv =====
// bit-serial remainder unit for periodic realignment
`timescale 1ns / 1ps
`default_nettype none
module rat_mod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rat_pkg::div_req_t req,
  output rat_pkg::div_rsp_t      rsp
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] dvd_r, dvd_nxt;
  logic [31:0] div_r, div_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] trial;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[32]};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      cnt_nxt = rat_pkg::DIV_STEPS;
      dvd_nxt = req.dividend;
      div_nxt = req.divisor;
      rem_nxt = '0;
    end else if (cnt_r != 6'd0) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = 32'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[31:0];
      end
      dvd_nxt  = {dvd_r[31:0], 1'b0};
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
endmodule
`default_nettype wire
